/* rtl/fifo_queue_with_remove_top_defines.svh */
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_top_defines
// assertion macros for the queue top rtl
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_REMOVE_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FQR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define FQR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fqr_pkg.sv */
// ----------------------------------------------------------------------------
// fqr_pkg
// shared constants, command codes and cell control type for the queue
// ----------------------------------------------------------------------------
package fqr_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	localparam int CMD_W   = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic              push;
		logic              pop;
		logic              remove;
		logic [DATA_W-1:0] value;
	} fqr_ctrl_t;

endpackage

/* rtl/fqr_cell.sv */
// ----------------------------------------------------------------------------
// fqr_cell
// one queue slot: holds a word, loads a push, shifts toward the head
// ----------------------------------------------------------------------------
module fqr_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fqr_pkg::fqr_ctrl_t        ctrl,
	input  logic                      left_valid,
	input  logic                      right_valid,
	input  logic [fqr_pkg::DATA_W-1:0] right_data,
	input  logic                      match_in,
	output logic                      match_out,
	output logic                      valid_q,
	output logic [fqr_pkg::DATA_W-1:0] data_q,
	output logic                      valid_d,
	output logic [fqr_pkg::DATA_W-1:0] data_d
);
	import fqr_pkg::*;

	logic hit;
	logic shift;
	logic load;

	assign hit       = valid_q && (data_q == ctrl.value);
	assign match_out = match_in || hit;

	// on a pop every slot, on a remove the slots at and after the first match, move up one place
	assign shift = ctrl.pop || (ctrl.remove && match_out);
	assign load  = ctrl.push && !valid_q && left_valid;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		if (shift) begin
			valid_d = right_valid;
			data_d  = right_data;
		end else if (load) begin
			valid_d = 1'b1;
			data_d  = ctrl.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

/* rtl/fifo_queue_with_remove_top.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_top
// bounded fifo of words with push, pop and remove-first-match commands
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries cmd and value; output channel
//   (out_valid / out_stall) carries one status transaction per command:
//   head word, head valid, entry count, match flag and drop flag.
//   the queue is a row of DEPTH slot cells; slot 0 is the head. a push loads
//   the first empty cell, a pop shifts every cell up by one, and a remove
//   compares all cells at once, then shifts the cells from the first match on.
//   the status is registered and appears in the cycle after the command transaction.
//   throughput: one command per cycle unless a status waits under out_stall;
//   the match search ripples combinationally through the row of cells.
//   in_stall rises only while a finished status waits under out_stall, so a
//   command is taken in the same cycle the pending status leaves.
//   reset clears every slot valid bit and the count and drops any pending
//   status; slot data are not cleared.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_remove_top_defines.svh"

module fifo_queue_with_remove_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fqr_pkg::CMD_W-1:0]   cmd,
	input  logic [fqr_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fqr_pkg::VALUE_W-1:0] head_value,
	output logic                        head_valid,
	output logic [fqr_pkg::COUNT_W-1:0] entry_count,
	output logic                        match_removed,
	output logic                        push_dropped
);
	import fqr_pkg::*;

	logic                        accept;
	fqr_ctrl_t                   ctrl;
	logic [DEPTH-1:0]            valid_vec;
	logic [DEPTH-1:0]            valid_nxt;
	logic [DATA_W-1:0]           data_vec [DEPTH];
	logic [DATA_W-1:0]           data_nxt [DEPTH];
	logic [DEPTH:0]              match_chain;
	logic                        found;
	logic                        full;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_d;
	logic                        out_valid_q;

	// a new command goes in unless a status is stuck at the output
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// command decode, gated by the accept so idle cycles leave cells alone
	assign ctrl.push   = accept && (cmd == CMD_PUSH);
	assign ctrl.pop    = accept && (cmd == CMD_POP);
	assign ctrl.remove = accept && (cmd == CMD_REMOVE);
	assign ctrl.value  = value[DATA_W-1:0];

	assign match_chain[0] = 1'b0;

	// row of slot cells, each talking to its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              left_v;
		logic              right_v;
		logic [DATA_W-1:0] right_d;

		if (i == 0) begin : g_head
			assign left_v = 1'b1;
		end else begin : g_body
			assign left_v = valid_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_v = 1'b0;
			assign right_d = '0;
		end else begin : g_inner
			assign right_v = valid_vec[i+1];
			assign right_d = data_vec[i+1];
		end

		fqr_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_valid  (left_v),
			.right_valid (right_v),
			.right_data  (right_d),
			.match_in    (match_chain[i]),
			.match_out   (match_chain[i+1]),
			.valid_q     (valid_vec[i]),
			.data_q      (data_vec[i]),
			.valid_d     (valid_nxt[i]),
			.data_d      (data_nxt[i])
		);
	end

	assign found = match_chain[DEPTH];
	assign full  = valid_vec[DEPTH-1];

	// entry count follows the cell activity
	always_comb begin
		count_d = count_q;
		if (ctrl.push && !full) begin
			count_d = count_q + CNT_W'(1);
		end else if ((ctrl.pop && valid_vec[0]) || (ctrl.remove && found)) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status register, loaded with the post-command view of the queue
	always_ff @(posedge clk) begin
		if (accept) begin
			head_value    <= valid_nxt[0] ? VALUE_W'(data_nxt[0]) : '0;
			head_valid    <= valid_nxt[0];
			entry_count   <= COUNT_W'(count_d);
			match_removed <= ctrl.remove && found;
			push_dropped  <= ctrl.push && full;
		end
	end

	assign out_valid = out_valid_q;

	// count and slot valid bits must tell the same story
	`FQR_ASSERT_NOW(a_count_matches, 1'b1, $countones(valid_vec) == 32'(count_q), "count disagrees with valid slots")
	// held entries always sit packed from the head
	`FQR_ASSERT_NOW(a_valid_packed, 1'b1, (valid_vec & (valid_vec + DEPTH'(1))) == '0, "gap in queue slots")
	// a remove that hits reports it and shortens the queue
	`FQR_ASSERT_NEXT(a_remove_hit, ctrl.remove && found, match_removed && out_valid && ($countones(valid_vec) + 1 == $countones($past(valid_vec))), "remove hit not reported")
	// a refused push leaves a full queue untouched
	`FQR_ASSERT_NEXT(a_push_drop, ctrl.push && full, push_dropped && valid_vec[DEPTH-1] && (head_value == $past(VALUE_W'(data_vec[0]))), "dropped push disturbed queue")

endmodule

/* tb/fifo_queue_with_remove_top_test.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_top_test
// self-checking bench for the word queue with push, pop and remove-first-match
// ----------------------------------------------------------------------------
// a short table of directed commands covers the empty queue, the full queue,
// duplicate words and the unused command code. after it come about 650 random
// commands in fill, drain and balanced phases. every accepted command
// transaction goes through a local queue model. the status it predicts, or
// the hand-written one of a typed table row, is compared field by field with
// each status transaction the block hands out. both sides idle at random,
// and the receiver holds off for long stretches so the block stalls its input.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_top_test;
	import fqr_pkg::*;

	// unused command code, must behave as a no-op
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

	localparam int RANDOM_CMDS = 650;
	localparam int PHASE_LEN   = 50;
	localparam int HOLD_CYCLES = 60;
	localparam int TIME_LIMIT  = 400000;

	typedef struct packed {
		logic [VALUE_W-1:0] head_value;
		logic               head_valid;
		logic [COUNT_W-1:0] entry_count;
		logic               match_removed;
		logic               push_dropped;
	} queue_status_t;

	// one row of the directed table; typed rows carry a hand-written status
	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [VALUE_W-1:0] word;
		logic               typed;
		queue_status_t      status;
	} directed_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [VALUE_W-1:0] head_value;
	logic               head_valid;
	logic [COUNT_W-1:0] entry_count;
	logic               match_removed;
	logic               push_dropped;

	// model of the queue contents, index 0 is the head
	logic [VALUE_W-1:0] queue_words[$];
	// predicted status for every accepted command, oldest first
	queue_status_t      pending_status[$];
	directed_row_t      directed_rows[$];

	int mismatch_count = 0;
	// no idling on either side while set
	bit no_idle = 1'b0;
	// asks the receiver for one long hold-off
	bit hold_off_req = 1'b0;

	fifo_queue_with_remove_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.head_value   (head_value),
		.head_valid   (head_valid),
		.entry_count  (entry_count),
		.match_removed(match_removed),
		.push_dropped (push_dropped)
	);

	// period 4
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one command to the queue model and returns the status it leaves
	function automatic queue_status_t apply_cmd(input logic [CMD_W-1:0] op,
			input logic [VALUE_W-1:0] word);
		queue_status_t s;
		int hit;
		s = '0;
		hit = -1;
		case (op)
			CMD_PUSH: begin
				if (queue_words.size() < DEPTH)
					queue_words.insert(queue_words.size(), word);
				else
					s.push_dropped = 1'b1;
			end
			CMD_POP: begin
				if (queue_words.size() > 0)
					void'(queue_words.pop_front());
			end
			CMD_REMOVE: begin
				// oldest matching entry goes, the rest keep their order
				for (int i = 0; i < queue_words.size(); i++)
					if (hit < 0 && queue_words[i] == word)
						hit = i;
				if (hit >= 0) begin
					queue_words.delete(hit);
					s.match_removed = 1'b1;
				end
			end
			default: ;
		endcase
		s.head_valid  = queue_words.size() > 0;
		s.head_value  = s.head_valid ? queue_words[0] : '0;
		s.entry_count = COUNT_W'(queue_words.size());
		return s;
	endfunction

	function automatic void add_row(input logic [CMD_W-1:0] op,
			input logic [VALUE_W-1:0] word, input logic typed,
			input logic [VALUE_W-1:0] hv, input logic hvalid,
			input logic [COUNT_W-1:0] cnt, input logic mr, input logic pd);
		directed_row_t row;
		row.op     = op;
		row.word   = word;
		row.typed  = typed;
		row.status = '{hv, hvalid, cnt, mr, pd};
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// command mix per phase: fill, drain, then balanced
	function automatic logic [CMD_W-1:0] pick_cmd(input int phase);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(0, 99);
		case (phase)
			0: begin
				push_pct = 65;
				pop_pct  = 15;
			end
			1: begin
				push_pct = 20;
				pop_pct  = 40;
			end
			default: begin
				push_pct = 40;
				pop_pct  = 25;
			end
		endcase
		if (r < push_pct)
			return CMD_PUSH;
		if (r < push_pct + pop_pct)
			return CMD_POP;
		if (r < 95)
			return CMD_REMOVE;
		return CMD_NOP;
	endfunction

	// removes mostly target a held word; a small pool makes duplicates common
	function automatic logic [VALUE_W-1:0] pick_word(input logic [CMD_W-1:0] op);
		int r;
		r = $urandom_range(0, 9);
		if (op == CMD_REMOVE && queue_words.size() > 0 && r < 6)
			return queue_words[$urandom_range(0, queue_words.size() - 1)];
		if (r < 4)
			return VALUE_W'($urandom_range(0, 7));
		if (r == 4)
			return '1;
		if (r == 5)
			return '0;
		return $urandom;
	endfunction

	// offers one command transaction and records its expected status once taken
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
			input logic typed, input queue_status_t typed_status);
		int gap;
		queue_status_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		// valid only drops when a gap follows, so it is never lowered and raised
		// in the same step
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_cmd(op, word);
		pending_status.insert(pending_status.size(), typed ? typed_status : predicted);
	endtask

	initial begin : stimulus
		int phase;
		logic [CMD_W-1:0] op;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = CMD_PUSH;
		value    = '0;

		// empty queue: pop, remove and the unused code all leave it empty
		add_row(CMD_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 5'd0, 1'b0, 1'b0);
		add_row(CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0, 5'd0, 1'b0, 1'b0);
		add_row(CMD_NOP,    32'h1234_5678, 1'b1, 32'h0000_0000, 1'b0, 5'd0, 1'b0, 1'b0);
		// extremes of the word
		add_row(CMD_PUSH,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 5'd1, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1, 5'd2, 1'b0, 1'b0);
		// remove with no match
		add_row(CMD_REMOVE, 32'h1234_5678, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		// fill to the top, with the word 5 held three times
		add_row(CMD_PUSH,   32'h0000_0005, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h8000_0000, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h7FFF_FFFF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h0000_0005, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'hA5A5_A5A5, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h5A5A_5A5A, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h0000_0001, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'hFFFF_FFFE, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h0000_FFFF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'hFFFF_0000, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h0000_0005, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h1357_9BDF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'h2468_ACE0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_PUSH,   32'hDEAD_BEEF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		// push onto a full queue is dropped and flagged
		add_row(CMD_PUSH,   32'h0BAD_F00D, 1'b1, 32'hFFFF_FFFF, 1'b1, 5'd16, 1'b0, 1'b1);
		// remove takes the oldest of the duplicates, then the head itself
		add_row(CMD_REMOVE, 32'h0000_0005, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		add_row(CMD_POP,    32'hFFFF_FFFF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
		// unused code on a non-empty queue
		add_row(CMD_NOP,    32'hFFFF_FFFF, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_cmd(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
				directed_rows[i].status);

		// random part: each phase of 50 commands is fill, drain, balanced or
		// balanced without idling; long hold-offs fall in the no-idle phases
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			phase   = (n / PHASE_LEN) % 4;
			no_idle = (phase == 3);
			if (n == 3 * PHASE_LEN || n == 7 * PHASE_LEN)
				hold_off_req = 1'b1;
			op = pick_cmd(phase);
			send_cmd(op, pick_word(op), 1'b0, '0);
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		// drain the outstanding status, then watch for strays
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS fifo_queue_with_remove_top");
		else
			$display("FAIL fifo_queue_with_remove_top");
		$finish;
	end

	// status receiver: random stall per transaction, plus requested hold-offs
	initial begin : status_sink
		int wait_cycles;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				wait_cycles  = HOLD_CYCLES;
			end else begin
				wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
		end
	end

	// every status transaction is checked against the oldest prediction
	always @(posedge clk) begin : status_check
		queue_status_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_status.size() == 0) begin
				$error("status transaction with no command waiting");
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				if (head_value !== want.head_value) begin
					$error("head_value expected %h got %h", want.head_value, head_value);
					mismatch_count++;
				end
				if (head_valid !== want.head_valid) begin
					$error("head_valid expected %b got %b", want.head_valid, head_valid);
					mismatch_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count expected %0d got %0d", want.entry_count, entry_count);
					mismatch_count++;
				end
				if (match_removed !== want.match_removed) begin
					$error("match_removed expected %b got %b", want.match_removed,
						match_removed);
					mismatch_count++;
				end
				if (push_dropped !== want.push_dropped) begin
					$error("push_dropped expected %b got %b", want.push_dropped, push_dropped);
					mismatch_count++;
				end
			end
		end
	end

	// hang guard
	initial begin : watchdog
		#(TIME_LIMIT);
		$display("FAIL fifo_queue_with_remove_top");
		$finish;
	end

endmodule
